/* rtl/fte_pkg.sv */
// Shared types, constants and the control program of the flux/torque estimator.
// Used by the interfaces, the sequencer, the datapath and the top level.
`timescale 1ns / 1ps

package fte_pkg;

  localparam int VOLT_W   = 16;
  localparam int CURR_W   = 16;
  localparam int RS_W     = 16;
  localparam int TS_W     = 24;
  localparam int HPF_W    = 16;
  localparam int FLUX_W   = 32;
  localparam int TORQUE_W = 32;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 2;

  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 54;

  localparam logic [RS_W-1:0]  RS_RESET  = 16'd1204;
  localparam logic [TS_W-1:0]  TS_RESET  = 24'd3355;
  localparam logic [HPF_W-1:0] HPF_RESET = 16'd65209;

  localparam logic [CFG_IDX_W-1:0] CFG_RS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HPF = 2'd2;

  // rounding shifts: flux increment Q12.44 -> Q8.24, filter Q8.40 -> Q8.24,
  // torque 9 * Q16.32 -> Q16.16 with the halving folded in
  localparam int INTEG_SH  = 20;
  localparam int HPF_SH    = 16;
  localparam int TORQUE_SH = 17;
  localparam int VOLT_ALIGN = 12;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_FIRST = 4'd1;
  localparam logic [STEP_W-1:0] STEP_LAST  = 4'd13;
  localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;

  localparam logic AX_D = 1'b0;
  localparam logic AX_Q = 1'b1;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_RS_I,
    MUL_ACC_TS,
    MUL_ACC_HPF,
    MUL_FD_IQ,
    MUL_FQ_ID
  } mul_op_t;

  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_VDIFF,
    ALU_INTEG,
    ALU_HPIN,
    ALU_HPOUT,
    ALU_LOAD,
    ALU_SUB,
    ALU_NINE
  } alu_op_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_END
  } jmp_t;

  typedef struct packed {
    mul_op_t mul_op;
    logic    mul_q;
    alu_op_t alu_op;
    logic    alu_q;
    logic    emit;
    jmp_t    jmp;
  } ctrl_t;

  function automatic ctrl_t cw(input mul_op_t m, input logic mq, input alu_op_t a,
                               input logic aq, input logic e, input jmp_t j);
    ctrl_t c;
    c.mul_op = m;
    c.mul_q  = mq;
    c.alu_op = a;
    c.alu_q  = aq;
    c.emit   = e;
    c.jmp    = j;
    return c;
  endfunction

  // control store: multiply result is usable in the step after the one that issues it
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    case (step)
      4'd0:    c = cw(MUL_NONE,    AX_D, ALU_NOP,   AX_D, 1'b0, JMP_WAIT_IN);
      4'd1:    c = cw(MUL_RS_I,    AX_D, ALU_NOP,   AX_D, 1'b0, JMP_NEXT);
      4'd2:    c = cw(MUL_RS_I,    AX_Q, ALU_VDIFF, AX_D, 1'b0, JMP_NEXT);
      4'd3:    c = cw(MUL_ACC_TS,  AX_D, ALU_VDIFF, AX_Q, 1'b0, JMP_NEXT);
      4'd4:    c = cw(MUL_ACC_TS,  AX_Q, ALU_INTEG, AX_D, 1'b0, JMP_NEXT);
      4'd5:    c = cw(MUL_NONE,    AX_D, ALU_INTEG, AX_Q, 1'b0, JMP_NEXT);
      4'd6:    c = cw(MUL_NONE,    AX_D, ALU_HPIN,  AX_D, 1'b0, JMP_NEXT);
      4'd7:    c = cw(MUL_ACC_HPF, AX_D, ALU_HPIN,  AX_Q, 1'b0, JMP_NEXT);
      4'd8:    c = cw(MUL_ACC_HPF, AX_Q, ALU_HPOUT, AX_D, 1'b0, JMP_NEXT);
      4'd9:    c = cw(MUL_FD_IQ,   AX_D, ALU_HPOUT, AX_Q, 1'b0, JMP_NEXT);
      4'd10:   c = cw(MUL_FQ_ID,   AX_D, ALU_LOAD,  AX_D, 1'b0, JMP_NEXT);
      4'd11:   c = cw(MUL_NONE,    AX_D, ALU_SUB,   AX_D, 1'b0, JMP_NEXT);
      4'd12:   c = cw(MUL_NONE,    AX_D, ALU_NINE,  AX_D, 1'b0, JMP_NEXT);
      4'd13:   c = cw(MUL_NONE,    AX_D, ALU_NOP,   AX_D, 1'b1, JMP_END);
      default: c = cw(MUL_NONE,    AX_D, ALU_NOP,   AX_D, 1'b0, JMP_END);
    endcase
    return c;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = 32'(x);
    end
    return r;
  endfunction

endpackage

/* rtl/fte_in_if.sv */
// Input channel of the flux/torque estimator: valid/ready plus one sample item.
// Depends on fte_pkg for field widths.
`timescale 1ns / 1ps

interface fte_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [fte_pkg::VOLT_W-1:0] volt_d;
  logic signed [fte_pkg::VOLT_W-1:0] volt_q;
  logic signed [fte_pkg::CURR_W-1:0] curr_d;
  logic signed [fte_pkg::CURR_W-1:0] curr_q;

  modport source (output valid, volt_d, volt_q, curr_d, curr_q, input ready);
  modport sink   (input valid, volt_d, volt_q, curr_d, curr_q, output ready);
endinterface

/* rtl/fte_out_if.sv */
// Output channel of the flux/torque estimator: valid/ready plus one result item.
// Depends on fte_pkg for field widths.
`timescale 1ns / 1ps

interface fte_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [fte_pkg::TORQUE_W-1:0] torque_est;
  logic signed [fte_pkg::FLUX_W-1:0]   flux_d_filtered;
  logic signed [fte_pkg::FLUX_W-1:0]   flux_q_filtered;

  modport source (output valid, torque_est, flux_d_filtered, flux_q_filtered, input ready);
  modport sink   (input valid, torque_est, flux_d_filtered, flux_q_filtered, output ready);
endinterface

/* rtl/fte_seq.sv */
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on fte_pkg (ctrl_t, ucode).
`timescale 1ns / 1ps

module fte_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           out_busy,
  output logic           in_ready,
  output fte_pkg::ctrl_t ctrl
);

  logic [fte_pkg::STEP_W-1:0] step;
  logic [fte_pkg::STEP_W-1:0] step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= fte_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    ctrl     = fte_pkg::ucode(step);
    in_ready = (ctrl.jmp == fte_pkg::JMP_WAIT_IN);
    case (ctrl.jmp)
      fte_pkg::JMP_NEXT:    step_next = step + 1'b1;
      fte_pkg::JMP_WAIT_IN: step_next = in_valid ? step + 1'b1 : step;
      fte_pkg::JMP_END:     step_next = out_busy ? step : fte_pkg::STEP_IDLE;
      default:              step_next = fte_pkg::STEP_IDLE;
    endcase
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= fte_pkg::STEP_LAST)
    else $error("sequencer step out of program");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (step == fte_pkg::STEP_FIRST))
    else $error("accepted item did not start the program");

  a_end_holds: assert property (@(posedge clk) disable iff (rst)
    (ctrl.jmp == fte_pkg::JMP_END && out_busy) |=> (step == $past(step)))
    else $error("program ended while result slot busy");

endmodule

/* rtl/fte_dp.sv */
// Datapath: config registers, flux/filter state, shared multiplier, accumulator, result register.
// Depends on fte_pkg; driven by the control word of fte_seq.
`timescale 1ns / 1ps

module fte_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fte_pkg::ctrl_t                       ctrl,
  input  logic                                 accept,
  input  logic signed [fte_pkg::VOLT_W-1:0]    volt_d,
  input  logic signed [fte_pkg::VOLT_W-1:0]    volt_q,
  input  logic signed [fte_pkg::CURR_W-1:0]    curr_d,
  input  logic signed [fte_pkg::CURR_W-1:0]    curr_q,
  input  logic                                 wr_en,
  input  logic [fte_pkg::CFG_IDX_W-1:0]        wr_index,
  input  logic [fte_pkg::CFG_W-1:0]            wr_data,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [fte_pkg::TORQUE_W-1:0]  torque_est,
  output logic signed [fte_pkg::FLUX_W-1:0]    flux_d_filtered,
  output logic signed [fte_pkg::FLUX_W-1:0]    flux_q_filtered
);

  logic [fte_pkg::RS_W-1:0]  rs;
  logic [fte_pkg::TS_W-1:0]  ts;
  logic [fte_pkg::HPF_W-1:0] hpf;

  logic signed [fte_pkg::VOLT_W-1:0] vd, vq;
  logic signed [fte_pkg::CURR_W-1:0] id, iq;

  logic signed [fte_pkg::FLUX_W-1:0] flux_d, flux_q, filt_d, filt_q, prev_d, prev_q;
  logic signed [fte_pkg::FLUX_W-1:0] flux_next, filt_next;

  logic signed [fte_pkg::MUL_A_W-1:0] mul_a;
  logic signed [fte_pkg::MUL_B_W-1:0] mul_b;
  logic signed [fte_pkg::PROD_W-1:0]  prod;
  logic signed [fte_pkg::ACC_W-1:0]   acc;
  logic signed [fte_pkg::ACC_W-1:0]   acc_next;

  logic signed [fte_pkg::VOLT_W-1:0] v_sel;
  logic signed [fte_pkg::CURR_W-1:0] i_mul;
  logic signed [fte_pkg::FLUX_W-1:0] flux_sel, filt_sel, prev_sel;
  logic signed [32:0]                vdiff;
  logic signed [fte_pkg::PROD_W-1:0] integ_inc, hp_rnd;
  logic signed [fte_pkg::ACC_W-1:0]  torque_rnd;
  logic                              out_busy;
  logic                              emit;

  assign out_busy = out_valid && !out_ready;
  assign emit     = ctrl.emit && !out_busy;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rs  <= fte_pkg::RS_RESET;
      ts  <= fte_pkg::TS_RESET;
      hpf <= fte_pkg::HPF_RESET;
    end else if (wr_en) begin
      case (wr_index)
        fte_pkg::CFG_RS:  rs  <= wr_data[fte_pkg::RS_W-1:0];
        fte_pkg::CFG_TS:  ts  <= wr_data[fte_pkg::TS_W-1:0];
        fte_pkg::CFG_HPF: hpf <= wr_data[fte_pkg::HPF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vd <= volt_d;
      vq <= volt_q;
      id <= curr_d;
      iq <= curr_q;
    end
  end

  // multiplier operand select
  always_comb begin
    i_mul = ctrl.mul_q ? iq : id;
    case (ctrl.mul_op)
      fte_pkg::MUL_RS_I: begin
        mul_a = fte_pkg::MUL_A_W'(i_mul);
        mul_b = fte_pkg::MUL_B_W'({1'b0, rs});
      end
      fte_pkg::MUL_ACC_TS: begin
        mul_a = acc[fte_pkg::MUL_A_W-1:0];
        mul_b = fte_pkg::MUL_B_W'({1'b0, ts});
      end
      fte_pkg::MUL_ACC_HPF: begin
        mul_a = acc[fte_pkg::MUL_A_W-1:0];
        mul_b = fte_pkg::MUL_B_W'({1'b0, hpf});
      end
      fte_pkg::MUL_FD_IQ: begin
        mul_a = fte_pkg::MUL_A_W'(filt_d);
        mul_b = fte_pkg::MUL_B_W'(iq);
      end
      fte_pkg::MUL_FQ_ID: begin
        mul_a = fte_pkg::MUL_A_W'(filt_q);
        mul_b = fte_pkg::MUL_B_W'(id);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_op != fte_pkg::MUL_NONE) begin
      prod <= mul_a * mul_b;
    end
  end

  // accumulator / state update
  always_comb begin
    v_sel    = ctrl.alu_q ? vq : vd;
    flux_sel = ctrl.alu_q ? flux_q : flux_d;
    filt_sel = ctrl.alu_q ? filt_q : filt_d;
    prev_sel = ctrl.alu_q ? prev_q : prev_d;

    vdiff      = (33'(v_sel) <<< fte_pkg::VOLT_ALIGN) - prod[32:0];
    integ_inc  = (prod + (fte_pkg::PROD_W'(1) <<< (fte_pkg::INTEG_SH - 1)))
                 >>> fte_pkg::INTEG_SH;
    hp_rnd     = (prod + (fte_pkg::PROD_W'(1) <<< (fte_pkg::HPF_SH - 1)))
                 >>> fte_pkg::HPF_SH;
    torque_rnd = (acc + (fte_pkg::ACC_W'(1) <<< (fte_pkg::TORQUE_SH - 1)))
                 >>> fte_pkg::TORQUE_SH;
    flux_next  = fte_pkg::sat32(64'(flux_sel) + 64'(integ_inc));
    filt_next  = fte_pkg::sat32(64'(hp_rnd));

    case (ctrl.alu_op)
      fte_pkg::ALU_VDIFF: acc_next = fte_pkg::ACC_W'(vdiff);
      fte_pkg::ALU_HPIN:  acc_next = fte_pkg::ACC_W'(filt_sel) + fte_pkg::ACC_W'(flux_sel)
                                     - fte_pkg::ACC_W'(prev_sel);
      fte_pkg::ALU_LOAD:  acc_next = fte_pkg::ACC_W'(prod);
      fte_pkg::ALU_SUB:   acc_next = acc - fte_pkg::ACC_W'(prod);
      fte_pkg::ALU_NINE:  acc_next = (acc <<< 3) + acc;   // 3/2 * 3 pole pairs, halved later
      default:            acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flux_d <= '0;
      flux_q <= '0;
      filt_d <= '0;
      filt_q <= '0;
      prev_d <= '0;
      prev_q <= '0;
    end else begin
      case (ctrl.alu_op)
        fte_pkg::ALU_INTEG: begin
          if (ctrl.alu_q) flux_q <= flux_next;
          else flux_d <= flux_next;
        end
        fte_pkg::ALU_HPIN: begin
          if (ctrl.alu_q) prev_q <= flux_q;
          else prev_d <= flux_d;
        end
        fte_pkg::ALU_HPOUT: begin
          if (ctrl.alu_q) filt_q <= filt_next;
          else filt_d <= filt_next;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      torque_est      <= fte_pkg::sat32(64'(torque_rnd));
      flux_d_filtered <= filt_d;
      flux_q_filtered <= filt_q;
    end
  end

  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl.emit))
    else $error("result valid without program end");

  a_no_emit_on_accept: assert property (@(posedge clk) disable iff (rst)
    accept |-> !ctrl.emit)
    else $error("input taken while result is being written");

  a_state_quiet_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> ($stable(filt_d) && $stable(flux_d) && $stable(prev_d)))
    else $error("state moved right after accept");

endmodule

/* rtl/flux_torque_estimator_top.sv */
// Top level of the stator flux and torque estimator.
// Depends on fte_pkg, fte_in_if, fte_out_if, fte_seq and fte_dp.
//
// Usage:
//   sample  (sink)  : one item per PWM period with volt_d, volt_q, curr_d, curr_q
//                     (signed Q8.8). Taken when valid and ready are both high.
//   result  (source): torque_est (Q16.16), flux_d_filtered and flux_q_filtered
//                     (Q8.24), one item per sample item.
//   wr_en/wr_index/wr_data: register writes (0 stator resistance, 1 sample
//                     period, 2 high-pass coefficient); other indexes are ignored.
//                     Write only while no item is in flight.
// Program: a 14-step control program on one shared 34x25 multiplier. The result
//   is registered when the last step ends; a new sample is taken only in the idle
//   step, after the program for the previous sample has finished.
// Reset: registers return to their defaults, all flux and filter state clears,
//   and the result channel goes empty.
// Stall: the finished result waits in the output register while the next sample
//   is taken and processed; that program holds on its last step, and no further
//   sample is taken, until the waiting result is taken.
`timescale 1ns / 1ps

module flux_torque_estimator_top (
  input  logic                              clk,
  input  logic                              rst,
  fte_in_if.sink                            sample,
  fte_out_if.source                         result,
  input  logic                              wr_en,
  input  logic [fte_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [fte_pkg::CFG_W-1:0]         wr_data
);

  fte_pkg::ctrl_t ctrl;
  logic           in_ready;
  logic           out_busy;

  assign sample.ready = in_ready;
  assign out_busy     = result.valid && !result.ready;

  fte_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .out_busy (out_busy),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  fte_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .accept          (sample.valid && in_ready),
    .volt_d          (sample.volt_d),
    .volt_q          (sample.volt_q),
    .curr_d          (sample.curr_d),
    .curr_q          (sample.curr_q),
    .wr_en           (wr_en),
    .wr_index        (wr_index),
    .wr_data         (wr_data),
    .out_ready       (result.ready),
    .out_valid       (result.valid),
    .torque_est      (result.torque_est),
    .flux_d_filtered (result.flux_d_filtered),
    .flux_q_filtered (result.flux_q_filtered)
  );

endmodule

/* bench/flux_torque_estimator_top_tb.sv */
// Self-checking bench for flux_torque_estimator_top: random and directed samples
// against a scoreboard that tracks flux, high-pass and torque state in longint.
// Depends on fte_pkg, fte_in_if, fte_out_if and the RTL of the estimator.
`timescale 1ns / 1ps

module flux_torque_estimator_top_tb;

  localparam logic [fte_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int SENDER     = 0;
  localparam int RECEIVER   = 1;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASE_ITEMS = 175;

  typedef struct {
    logic signed [fte_pkg::TORQUE_W-1:0] torque;
    logic signed [fte_pkg::FLUX_W-1:0]   flux_d;
    logic signed [fte_pkg::FLUX_W-1:0]   flux_q;
  } torque_flux_t;

  class flux_torque_scoreboard;
    torque_flux_t expected_q[$];
    longint rs_ohm, ts_sec, hpf_a;
    longint flux_d, flux_q, filt_d, filt_q, prev_d, prev_q;
    int mismatches;

    function new();
      rs_ohm = fte_pkg::RS_RESET;
      ts_sec = fte_pkg::TS_RESET;
      hpf_a = fte_pkg::HPF_RESET;
      flux_d = 0;
      flux_q = 0;
      filt_d = 0;
      filt_q = 0;
      prev_d = 0;
      prev_q = 0;
      mismatches = 0;
    endfunction

    function void apply_write(logic [fte_pkg::CFG_IDX_W-1:0] idx,
                              logic [fte_pkg::CFG_W-1:0] data);
      case (idx)
        fte_pkg::CFG_RS: begin
          rs_ohm = data[fte_pkg::RS_W-1:0];
        end
        fte_pkg::CFG_TS: begin
          ts_sec = data[fte_pkg::TS_W-1:0];
        end
        fte_pkg::CFG_HPF: begin
          hpf_a = data[fte_pkg::HPF_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    // round half up, then floor
    function longint round_shr(longint x, int s);
      return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint integrate_axis(longint acc, longint v, longint i);
      longint diff;
      diff = v * 4096 - rs_ohm * i;
      return clamp32(acc + round_shr(diff * ts_sec, 20));
    endfunction

    function longint highpass(longint y, longint x, longint x_prev);
      return clamp32(round_shr(hpf_a * y + hpf_a * (x - x_prev), 16));
    endfunction

    function void note_sample(logic signed [fte_pkg::VOLT_W-1:0] vd,
                              logic signed [fte_pkg::VOLT_W-1:0] vq,
                              logic signed [fte_pkg::CURR_W-1:0] id,
                              logic signed [fte_pkg::CURR_W-1:0] iq);
      longint id_l, iq_l;
      torque_flux_t e;
      id_l = id;
      iq_l = iq;
      flux_d = integrate_axis(flux_d, vd, id_l);
      flux_q = integrate_axis(flux_q, vq, iq_l);
      filt_d = highpass(filt_d, flux_d, prev_d);
      prev_d = flux_d;
      filt_q = highpass(filt_q, flux_q, prev_q);
      prev_q = flux_q;
      e.torque = 32'(clamp32(round_shr(9 * (filt_d * iq_l - filt_q * id_l), 17)));
      e.flux_d = 32'(filt_d);
      e.flux_q = 32'(filt_q);
      expected_q.push_back(e);
    endfunction

    task report(string msg);
      if (mismatches < 50) $display("ERROR: %s", msg);
      mismatches++;
    endtask

    task check_result(logic signed [fte_pkg::TORQUE_W-1:0] t,
                      logic signed [fte_pkg::FLUX_W-1:0] fd,
                      logic signed [fte_pkg::FLUX_W-1:0] fq);
      torque_flux_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result item, torque %0d", t));
        return;
      end
      e = expected_q.pop_front();
      if (t !== e.torque) report($sformatf("torque_est %0d, want %0d", t, e.torque));
      if (fd !== e.flux_d) report($sformatf("flux_d_filtered %0d, want %0d", fd, e.flux_d));
      if (fq !== e.flux_q) report($sformatf("flux_q_filtered %0d, want %0d", fq, e.flux_q));
    endtask
  endclass

  logic clk;
  logic rst;
  logic wr_en;
  logic [fte_pkg::CFG_IDX_W-1:0] wr_index;
  logic [fte_pkg::CFG_W-1:0] wr_data;
  int idle_cycles;
  bit calm [2];

  fte_in_if sample_ch();
  fte_out_if result_ch();

  flux_torque_scoreboard board = new();

  flux_torque_estimator_top u_top (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample_ch),
    .result   (result_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // per-side gap, with stretches of back-to-back traffic
  function automatic int draw_gap(input int side);
    if ($urandom_range(0, 19) == 0) calm[side] = ~calm[side];
    return calm[side] ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic logic signed [15:0] draw_field();
    logic signed [15:0] corner [4];
    corner[0] = 16'sh7fff;
    corner[1] = 16'sh8000;
    corner[2] = 16'sh0000;
    corner[3] = 16'shffff;
    case ($urandom_range(0, 7))
      0: return corner[$urandom_range(0, 3)];
      1, 2, 3: return 16'($urandom_range(0, 4095)) - 16'sd2048;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic signed [15:0] vd, input logic signed [15:0] vq,
                             input logic signed [15:0] id, input logic signed [15:0] iq);
    int gap;
    gap = draw_gap(SENDER);
    @(negedge clk);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.volt_d <= vd;
    sample_ch.volt_q <= vq;
    sample_ch.curr_d <= id;
    sample_ch.curr_q <= iq;
    do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
  endtask

  task automatic send_random(input int count);
    repeat (count) send_sample(draw_field(), draw_field(), draw_field(), draw_field());
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [fte_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fte_pkg::CFG_W-1:0] data);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
  endtask

  task automatic program_regs(input logic [fte_pkg::RS_W-1:0] rs,
                              input logic [fte_pkg::TS_W-1:0] ts,
                              input logic [fte_pkg::HPF_W-1:0] hpf);
    cfg_write(fte_pkg::CFG_RS, {8'($urandom), rs});
    cfg_write(fte_pkg::CFG_TS, ts);
    cfg_write(fte_pkg::CFG_HPF, {8'($urandom), hpf});
    cfg_write(CFG_UNUSED, 24'($urandom));
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (wr_en) board.apply_write(wr_index, wr_data);
      if (sample_ch.valid && sample_ch.ready) begin
        board.note_sample(sample_ch.volt_d, sample_ch.volt_q, sample_ch.curr_d, sample_ch.curr_q);
      end
      if (result_ch.valid && result_ch.ready) begin
        board.check_result(result_ch.torque_est, result_ch.flux_d_filtered,
                           result_ch.flux_q_filtered);
      end
      if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // receiver: once a result shows up, hold off for the drawn number of cycles
  initial begin
    int gap;
    result_ch.ready = 1'b0;
    forever begin
      gap = draw_gap(RECEIVER);
      @(negedge clk);
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        do @(posedge clk); while (result_ch.valid !== 1'b1);
        repeat (gap) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
    end
  end

  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = fte_pkg::CFG_RS;
    wr_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.volt_d = '0;
    sample_ch.volt_q = '0;
    sample_ch.curr_d = '0;
    sample_ch.curr_q = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: zero, full-scale and +/-1 items
    send_sample(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    send_sample(16'shffff, 16'sh0001, 16'shffff, 16'sh0001);
    drain();

    // no resistance, longest period, slowest filter: integrator, filter and torque clip
    program_regs(16'h0000, 24'hffffff, 16'hffff);
    repeat (3) send_sample(16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0000);
    repeat (3) send_sample(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
    repeat (2) send_sample(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff);
    drain();

    // largest resistance, zero period, zero coefficient
    program_regs(16'hffff, 24'h000000, 16'h0000);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff);
    drain();

    program_regs(fte_pkg::RS_RESET, fte_pkg::TS_RESET, fte_pkg::HPF_RESET);
    send_random(PHASE_ITEMS);
    drain();

    program_regs(16'($urandom), 24'($urandom), 16'($urandom));
    send_random(PHASE_ITEMS);
    drain();

    program_regs(16'hffff, 24'hffffff, 16'hffff);
    send_random(PHASE_ITEMS);
    drain();

    program_regs(16'($urandom_range(0, 8191)), 24'($urandom_range(0, 65535)),
                 16'($urandom_range(60000, 65535)));
    send_random(PHASE_ITEMS);
    drain();

    program_regs(16'h0000, 24'h000001, 16'h0001);
    send_random(PHASE_ITEMS);
    drain();

    program_regs(16'($urandom), 24'($urandom), 16'($urandom));
    send_random(PHASE_ITEMS);
    drain();

    repeat (16) @(posedge clk);
    if (board.expected_q.size() != 0) begin
      board.report($sformatf("%0d results never arrived", board.expected_q.size()));
    end
    if (board.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
